// File: design/assert_macros.svh
// Assertion macros shared by the design files.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Condition that must hold at every clock edge outside reset.
`define SGBP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Condition that must hold in the cycle after a trigger.
`define SGBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: design/sgbp_pkg.sv
// Package for the staggered grid path search: state type, codes and helpers.
// No dependencies; used by sgbp_move and staggered_grid_bfs_path.
package sgbp_pkg;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CLR, S_START, S_POP, S_CELL, S_NB_RD, S_NB_WR,
      S_TRACE_RD, S_TRACE_WR, S_READ, S_EMIT
   } sgbp_state_type;

   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_SEARCH = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_PATH  = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;
   localparam logic [1:0] ST_PAST_END = 2'd3;

   localparam logic [2:0] DIR_UP2       = 3'd0;
   localparam logic [2:0] DIR_UPRIGHT   = 3'd1;
   localparam logic [2:0] DIR_RIGHT     = 3'd2;
   localparam logic [2:0] DIR_DOWNRIGHT = 3'd3;
   localparam logic [2:0] DIR_DOWN2     = 3'd4;
   localparam logic [2:0] DIR_DOWNLEFT  = 3'd5;
   localparam logic [2:0] DIR_LEFT      = 3'd6;
   localparam logic [2:0] DIR_UPLEFT    = 3'd7;

   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_LIMIT = 1'b1;

   // Neighbor visiting order; fight mode uses the first four only.
   function automatic logic [2:0] walk_dir(input logic [2:0] k);
      logic [2:0] d;
      case (k)
         3'd0: d = DIR_UPRIGHT;
         3'd1: d = DIR_DOWNRIGHT;
         3'd2: d = DIR_UPLEFT;
         3'd3: d = DIR_DOWNLEFT;
         3'd4: d = DIR_DOWN2;
         3'd5: d = DIR_UP2;
         3'd6: d = DIR_RIGHT;
         default: d = DIR_LEFT;
      endcase
      return d;
   endfunction

   function automatic logic [7:0] sat8(input logic [31:0] v);
      return (v > 32'd255) ? 8'hFF : v[7:0];
   endfunction

endpackage

// File: design/sgbp_req_if.sv
// Request channel of the staggered grid path search.
// No dependencies.
interface sgbp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [4:0] x_pos;
   logic [5:0] y_pos;
   logic [4:0] target_x;
   logic [5:0] target_y;
   logic       blocked_bit;

   modport source (output valid, action, x_pos, y_pos, target_x, target_y, blocked_bit,
                   input ready);
   modport sink (input valid, action, x_pos, y_pos, target_x, target_y, blocked_bit,
                 output ready);
endinterface

// File: design/sgbp_rsp_if.sv
// Response channel of the staggered grid path search.
// No dependencies.
interface sgbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] path_length;
   logic [2:0] direction;
   logic       last_step;

   modport source (output valid, status, path_length, direction, last_step, input ready);
   modport sink (input valid, status, path_length, direction, last_step, output ready);
endinterface

// File: design/sgbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sgbp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/sgbp_move.sv
// One step on the staggered grid: neighbor coordinates and map bounds check.
// Depends on sgbp_pkg for the direction codes.
module sgbp_move #(
   parameter int MAP_WIDTH  = 32,
   parameter int MAP_HEIGHT = 64
) (
   input  logic [$clog2(MAP_WIDTH)-1:0]  cell_x,
   input  logic [$clog2(MAP_HEIGHT)-1:0] cell_y,
   input  logic [2:0]                    dir,
   output logic [$clog2(MAP_WIDTH)-1:0]  next_x,
   output logic [$clog2(MAP_HEIGHT)-1:0] next_y,
   output logic                          in_map
);
   import sgbp_pkg::*;

   localparam int XW  = $clog2(MAP_WIDTH);
   localparam int YW  = $clog2(MAP_HEIGHT);
   localparam int XW2 = XW + 2;
   localparam int YW2 = YW + 2;

   logic               odd;
   logic signed [1:0]  dx;
   logic signed [2:0]  dy;
   logic signed [XW2-1:0] xs;
   logic signed [YW2-1:0] ys;

   assign odd = cell_y[0];

   // Diagonal steps shift by one column depending on the row parity.
   always_comb begin
      dx = 2'sd0;
      dy = 3'sd0;
      case (dir)
         DIR_UP2:       dy = -3'sd2;
         DIR_DOWN2:     dy = 3'sd2;
         DIR_RIGHT:     dx = 2'sd1;
         DIR_LEFT:      dx = -2'sd1;
         DIR_UPRIGHT:   begin dy = -3'sd1; dx = odd ? 2'sd1 : 2'sd0;  end
         DIR_DOWNRIGHT: begin dy = 3'sd1;  dx = odd ? 2'sd1 : 2'sd0;  end
         DIR_DOWNLEFT:  begin dy = 3'sd1;  dx = odd ? 2'sd0 : -2'sd1; end
         default:       begin dy = -3'sd1; dx = odd ? 2'sd0 : -2'sd1; end
      endcase
   end

   assign xs = $signed({2'b00, cell_x}) + XW2'(dx);
   assign ys = $signed({2'b00, cell_y}) + YW2'(dy);

   assign in_map = !xs[XW2-1] && !ys[YW2-1]
                   && (xs < $signed(XW2'(MAP_WIDTH)))
                   && (ys < $signed(YW2'(MAP_HEIGHT)));
   assign next_x = xs[XW-1:0];
   assign next_y = ys[YW-1:0];
endmodule

// File: design/staggered_grid_bfs_path.sv
// Breadth-first shortest path on a staggered grid, state held in block RAMs.
// Each search first clears the visited RAM in one pass over its addresses, then takes the
// queued cells in order and probes the neighbors of each (an in-map neighbor is read, then
// marked and queued if free), traces the path back from the target into the path RAM and
// emits the result. Transactions are handled one at a time.
// After reset the obstacle RAM is cleared in one pass; registers reset to walk, 255.
`include "assert_macros.svh"
module staggered_grid_bfs_path #(
   parameter int MAP_WIDTH  = 32,
   parameter int MAP_HEIGHT = 64,
   parameter int MAX_PATH   = 128
) (
   input  logic         clock,
   input  logic         reset,
   sgbp_req_if.sink     req_chan,
   sgbp_rsp_if.source   rsp_chan,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata
);
   import sgbp_pkg::*;

   localparam int XW    = $clog2(MAP_WIDTH);
   localparam int YW    = $clog2(MAP_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int CELLS = 1 << AW;
   localparam int PW    = $clog2(MAX_PATH);
   localparam int LW    = $clog2(MAX_PATH + 1);

   sgbp_state_type state_ff, state_in;
   logic [AW-1:0]  sweep_ff, sweep_in;
   logic [AW:0]    head_ff, head_in, tail_ff, tail_in, lend_ff, lend_in, lvl_ff, lvl_in;
   logic [LW-1:0]  stored_len_ff, stored_len_in, rp_ff, rp_in, i_ff, i_in;
   logic           mode_ff;
   logic [7:0]     limit_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [7:0]     rsp_len_ff, rsp_len_in;
   logic [2:0]     rsp_dir_ff, rsp_dir_in;
   logic           rsp_last_ff, rsp_last_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [7:0]     res_len_ff, res_len_in;
   logic [2:0]     res_dir_ff, res_dir_in;
   logic           res_last_ff, res_last_in;
   logic [4:0]     sx_ff, sx_in, tx_ff, tx_in;
   logic [5:0]     sy_ff, sy_in, ty_ff, ty_in;
   logic [XW-1:0]  cur_x_ff, cur_x_in;
   logic [YW-1:0]  cur_y_ff, cur_y_in;
   logic [2:0]     k_ff, k_in, dir_ff, dir_in;
   logic [AW-1:0]  nb_ff, nb_in;

   logic           obs_we, obs_wdata, obs_rdata;
   logic [AW-1:0]  obs_waddr, obs_raddr;
   logic           mark_we;
   logic [3:0]     mark_wdata, mark_rdata;
   logic [AW-1:0]  mark_waddr, mark_raddr;
   logic           q_we;
   logic [AW-1:0]  q_waddr, q_wdata, q_raddr, q_rdata;
   logic           path_we;
   logic [2:0]     path_wdata, path_rdata;
   logic [PW-1:0]  path_waddr, path_raddr;

   logic [2:0]     mv_dir;
   logic [XW-1:0]  mv_nx;
   logic [YW-1:0]  mv_ny;
   logic           mv_inb;

   logic           accept, emit_free, sweep_last, start_inb, wr_inb, q_nonempty;
   logic           depth_stop, hit, lvl_big, k_last, rp_lt;
   logic [AW:0]    lvl_pop;
   logic [LW-1:0]  i_dec, rp_inc;
   logic [AW-1:0]  start_addr, nb_addr;

   sgbp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obstacle_ram (
      .clock(clock), .wr_en(obs_we), .wr_addr(obs_waddr), .wr_data(obs_wdata),
      .rd_addr(obs_raddr), .rd_data(obs_rdata)
   );

   // Visited flag in the top bit, parent direction below it.
   sgbp_ram #(.WIDTH(4), .DEPTH(CELLS)) u_mark_ram (
      .clock(clock), .wr_en(mark_we), .wr_addr(mark_waddr), .wr_data(mark_wdata),
      .rd_addr(mark_raddr), .rd_data(mark_rdata)
   );

   sgbp_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_queue_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata)
   );

   sgbp_ram #(.WIDTH(3), .DEPTH(MAX_PATH)) u_path_ram (
      .clock(clock), .wr_en(path_we), .wr_addr(path_waddr), .wr_data(path_wdata),
      .rd_addr(path_raddr), .rd_data(path_rdata)
   );

   // The tracer walks backwards, so it steps opposite to the stored parent direction.
   assign mv_dir = (state_ff == S_TRACE_WR) ? (mark_rdata[2:0] + 3'd4) : walk_dir(k_ff);

   sgbp_move #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_move (
      .cell_x(cur_x_ff), .cell_y(cur_y_ff), .dir(mv_dir),
      .next_x(mv_nx), .next_y(mv_ny), .in_map(mv_inb)
   );

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign accept           = req_chan.valid && (state_ff == S_IDLE);
   assign emit_free        = !rsp_valid_ff || rsp_chan.ready;
   assign sweep_last       = (sweep_ff == '1);
   assign start_inb        = (32'(sx_ff) < 32'(MAP_WIDTH)) && (32'(sy_ff) < 32'(MAP_HEIGHT));
   assign wr_inb           = (32'(req_chan.x_pos) < 32'(MAP_WIDTH))
                             && (32'(req_chan.y_pos) < 32'(MAP_HEIGHT));
   assign start_addr       = {YW'(sy_ff), XW'(sx_ff)};
   assign nb_addr          = {mv_ny, mv_nx};
   assign q_nonempty       = head_ff < tail_ff;
   assign lvl_pop          = (head_ff == lend_ff) ? lvl_ff + 1'b1 : lvl_ff;
   assign depth_stop       = mode_ff && (32'(lvl_pop) >= 32'(limit_ff));
   assign hit              = (32'(q_rdata[XW-1:0]) == 32'(tx_ff))
                             && (32'(q_rdata[AW-1:XW]) == 32'(ty_ff));
   assign lvl_big          = 32'(lvl_ff) > 32'(MAX_PATH);
   assign k_last           = (k_ff == (mode_ff ? 3'd3 : 3'd7));
   assign rp_lt            = rp_ff < stored_len_ff;
   assign i_dec            = i_ff - 1'b1;
   assign rp_inc           = rp_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.action)
                  ACT_SEARCH: state_in = S_CLR;
                  ACT_READ:   state_in = rp_lt ? S_READ : S_EMIT;
                  default:    state_in = S_EMIT;
               endcase
            end
         end
         S_CLR: begin
            if (sweep_last) state_in = start_inb ? S_START : S_EMIT;
         end
         S_START: state_in = S_POP;
         S_POP: begin
            state_in = (!q_nonempty || depth_stop) ? S_EMIT : S_CELL;
         end
         S_CELL: begin
            if (hit) begin
               state_in = (lvl_big || (lvl_ff == '0)) ? S_EMIT : S_TRACE_RD;
            end else begin
               state_in = S_NB_RD;
            end
         end
         S_NB_RD: begin
            if (mv_inb) state_in = S_NB_WR;
            else if (k_last) state_in = S_POP;
         end
         S_NB_WR: state_in = k_last ? S_POP : S_NB_RD;
         S_TRACE_RD: state_in = S_TRACE_WR;
         S_TRACE_WR: begin
            state_in = ((i_ff == LW'(1)) || !mv_inb) ? S_EMIT : S_TRACE_RD;
         end
         S_READ: state_in = S_EMIT;
         S_EMIT: begin
            if (emit_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      sweep_in      = sweep_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      lend_in       = lend_ff;
      lvl_in        = lvl_ff;
      stored_len_in = stored_len_ff;
      rp_in         = rp_ff;
      i_in          = i_ff;
      res_status_in = res_status_ff;
      res_len_in    = res_len_ff;
      res_dir_in    = res_dir_ff;
      res_last_in   = res_last_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      k_in          = k_ff;
      dir_in        = dir_ff;
      nb_in         = nb_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_last_in   = rsp_last_ff;
      obs_we        = 1'b0;
      obs_waddr     = sweep_ff;
      obs_wdata     = 1'b0;
      obs_raddr     = nb_addr;
      mark_we       = 1'b0;
      mark_waddr    = sweep_ff;
      mark_wdata    = 4'd0;
      mark_raddr    = nb_addr;
      q_we          = 1'b0;
      q_waddr       = tail_ff[AW-1:0];
      q_wdata       = nb_ff;
      q_raddr       = head_ff[AW-1:0];
      path_we       = 1'b0;
      path_waddr    = i_dec[PW-1:0];
      path_wdata    = mark_rdata[2:0];
      path_raddr    = rp_ff[PW-1:0];
      case (state_ff)
         S_INIT: begin
            obs_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               res_status_in = ST_OK;
               res_len_in    = sat8(32'(stored_len_ff));
               res_dir_in    = 3'd0;
               res_last_in   = 1'b0;
               case (req_chan.action)
                  ACT_SEARCH: begin
                     sx_in         = req_chan.x_pos;
                     sy_in         = req_chan.y_pos;
                     tx_in         = req_chan.target_x;
                     ty_in         = req_chan.target_y;
                     stored_len_in = '0;
                     rp_in         = '0;
                     sweep_in      = '0;
                  end
                  ACT_READ: begin
                     if (!rp_lt) res_status_in = ST_PAST_END;
                  end
                  ACT_WRITE: begin
                     obs_we    = wr_inb;
                     obs_waddr = {YW'(req_chan.y_pos), XW'(req_chan.x_pos)};
                     obs_wdata = req_chan.blocked_bit;
                  end
                  default: ;
               endcase
            end
         end
         S_CLR: begin
            mark_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last && !start_inb) begin
               res_status_in = ST_NO_PATH;
               res_len_in    = 8'd0;
            end
         end
         S_START: begin
            // The start is marked visited even when it is blocked.
            mark_we    = 1'b1;
            mark_waddr = start_addr;
            mark_wdata = 4'b1000;
            q_we       = 1'b1;
            q_waddr    = '0;
            q_wdata    = start_addr;
            head_in    = '0;
            tail_in    = (AW+1)'(1);
            lend_in    = (AW+1)'(1);
            lvl_in     = '0;
         end
         S_POP: begin
            if (!q_nonempty || depth_stop) begin
               res_status_in = ST_NO_PATH;
               res_len_in    = 8'd0;
            end else begin
               head_in = head_ff + 1'b1;
               lvl_in  = lvl_pop;
               if (head_ff == lend_ff) lend_in = tail_ff;
            end
         end
         S_CELL: begin
            cur_x_in = q_rdata[XW-1:0];
            cur_y_in = q_rdata[AW-1:XW];
            k_in     = 3'd0;
            if (hit) begin
               if (lvl_big) begin
                  res_status_in = ST_TOO_LONG;
                  res_len_in    = sat8(32'(lvl_ff));
               end else begin
                  res_status_in = ST_OK;
                  res_len_in    = sat8(32'(lvl_ff));
                  i_in          = LW'(lvl_ff);
               end
            end
         end
         S_NB_RD: begin
            if (mv_inb) begin
               nb_in  = nb_addr;
               dir_in = mv_dir;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_NB_WR: begin
            k_in = k_ff + 1'b1;
            if (!obs_rdata && !mark_rdata[3]) begin
               mark_we    = 1'b1;
               mark_waddr = nb_ff;
               mark_wdata = {1'b1, dir_ff};
               q_we       = 1'b1;
               tail_in    = tail_ff + 1'b1;
            end
         end
         S_TRACE_RD: begin
            mark_raddr = {cur_y_ff, cur_x_ff};
         end
         S_TRACE_WR: begin
            path_we  = 1'b1;
            cur_x_in = mv_nx;
            cur_y_in = mv_ny;
            i_in     = i_dec;
            if ((i_ff == LW'(1)) || !mv_inb) stored_len_in = LW'(lvl_ff);
         end
         S_READ: begin
            res_dir_in  = path_rdata;
            res_last_in = (rp_inc == stored_len_ff);
            rp_in       = rp_inc;
         end
         S_EMIT: begin
            if (emit_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_len_in    = res_len_ff;
               rsp_dir_in    = res_dir_ff;
               rsp_last_in   = res_last_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         sweep_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         stored_len_ff <= '0;
         rp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= 1'b0;
         limit_ff      <= 8'd255;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         stored_len_ff <= stored_len_in;
         rp_ff         <= rp_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_MODE:  mode_ff  <= csr_wdata[0];
               REG_LIMIT: limit_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      lend_ff       <= lend_in;
      lvl_ff        <= lvl_in;
      i_ff          <= i_in;
      res_status_ff <= res_status_in;
      res_len_ff    <= res_len_in;
      res_dir_ff    <= res_dir_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_last_ff   <= rsp_last_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      tx_ff         <= tx_in;
      ty_ff         <= ty_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      k_ff          <= k_in;
      dir_ff        <= dir_in;
      nb_ff         <= nb_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.path_length = rsp_len_ff;
   assign rsp_chan.direction   = rsp_dir_ff;
   assign rsp_chan.last_step   = rsp_last_ff;

   `SGBP_ASSERT_ALWAYS(a_queue_order, clock, reset, head_ff <= tail_ff,
                       "queue head passed tail")
   `SGBP_ASSERT_ALWAYS(a_read_bound, clock, reset, rp_ff <= stored_len_ff,
                       "read pointer past path")
   `SGBP_ASSERT_ALWAYS(a_len_bound, clock, reset, 32'(stored_len_ff) <= 32'(MAX_PATH),
                       "path too long")
   `SGBP_ASSERT_NEXT(a_search_start, clock, reset,
                     req_chan.valid && req_chan.ready && (req_chan.action == ACT_SEARCH),
                     (state_ff == S_CLR) && (stored_len_ff == '0),
                     "search did not start clean")
endmodule

// File: tb/tb_chan_if.sv
`timescale 1ns / 1ps
// Testbench-side note: the block's channel interfaces come from the design folder.
// This file only groups the shared test types; it depends on sgbp_pkg.
package tb_grid_types;
   import sgbp_pkg::*;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] x_pos;
      logic [5:0] y_pos;
      logic [4:0] target_x;
      logic [5:0] target_y;
      logic       blocked_bit;
   } grid_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] path_length;
      logic [2:0] direction;
      logic       last_step;
   } grid_rsp_type;
endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for staggered_grid_bfs_path: directed and random transactions checked
// against an in-bench breadth-first search predictor. Depends on sgbp_pkg and the interfaces.
module tb;
   import sgbp_pkg::*;
   import tb_grid_types::*;

   localparam int GW = 32;
   localparam int GH = 64;
   localparam int CELLS = GW * GH;
   localparam int PATH_CAP = 128;
   localparam int STALL_LIMIT = 200000;
   // Action code with no function; the block answers it like a write.
   localparam logic [1:0] ACT_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [7:0] csr_wdata = '0;

   sgbp_req_if req_chan ();
   sgbp_rsp_if rsp_chan ();

   staggered_grid_bfs_path uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   bit         blocked_cells [CELLS];
   bit         seen_cells [CELLS];
   logic [2:0] came_from [CELLS];
   int         bfs_queue [CELLS];
   logic [2:0] path_steps [PATH_CAP];
   int         step_ptr;
   int         path_count;
   bit         fight_mode;
   int         level_cap;

   grid_rsp_type expected_rsps [$];
   int mismatches = 0;
   int stall_cycles = 0;
   bit hold_rsp = 1'b0;
   bit timed_out = 1'b0;

   function automatic bit step_cell(input int x, input int y, input logic [2:0] dir,
                                    output int nx, output int ny);
      int dx;
      int dy;
      bit odd;
      dx = 0;
      dy = 0;
      odd = y[0];
      case (dir)
         DIR_UP2:       dy = -2;
         DIR_DOWN2:     dy = 2;
         DIR_RIGHT:     dx = 1;
         DIR_LEFT:      dx = -1;
         DIR_UPRIGHT:   begin dy = -1; dx = odd ? 1 : 0; end
         DIR_DOWNRIGHT: begin dy = 1; dx = odd ? 1 : 0; end
         DIR_DOWNLEFT:  begin dy = 1; dx = odd ? 0 : -1; end
         default:       begin dy = -1; dx = odd ? 0 : -1; end
      endcase
      nx = x + dx;
      ny = y + dy;
      return nx >= 0 && ny >= 0 && nx < GW && ny < GH;
   endfunction

   function automatic logic [2:0] probe_dir(input int k);
      logic [2:0] order [8];
      order = '{DIR_UPRIGHT, DIR_DOWNRIGHT, DIR_UPLEFT, DIR_DOWNLEFT,
                DIR_DOWN2, DIR_UP2, DIR_RIGHT, DIR_LEFT};
      return order[k];
   endfunction

   function automatic logic [1:0] find_path(input int sx, input int sy, input int tx,
                                            input int ty, output int report);
      int head;
      int tail;
      int lvl;
      int lend;
      int cnt;
      int c;
      int cx;
      int cy;
      int nx;
      int ny;
      int ni;
      bit found;
      logic [2:0] d;
      head = 0;
      tail = 0;
      lvl = 0;
      found = 0;
      seen_cells = blocked_cells;
      path_count = 0;
      step_ptr = 0;
      report = 0;
      seen_cells[sy * GW + sx] = 1'b1;
      bfs_queue[tail++] = sy * GW + sx;
      lend = tail;
      cnt = fight_mode ? 4 : 8;
      while (head < tail) begin
         if (head == lend) begin
            lvl++;
            lend = tail;
         end
         if (fight_mode && lvl >= level_cap) break;
         c = bfs_queue[head++];
         cx = c % GW;
         cy = c / GW;
         if (cx == tx && cy == ty) begin
            found = 1;
            break;
         end
         for (int k = 0; k < cnt; k++) begin
            d = probe_dir(k);
            if (step_cell(cx, cy, d, nx, ny)) begin
               ni = ny * GW + nx;
               if (!seen_cells[ni]) begin
                  seen_cells[ni] = 1'b1;
                  came_from[ni] = d;
                  bfs_queue[tail++] = ni;
               end
            end
         end
      end
      if (!found) return ST_NO_PATH;
      if (lvl > PATH_CAP) begin
         report = lvl > 255 ? 255 : lvl;
         return ST_TOO_LONG;
      end
      cx = tx;
      cy = ty;
      for (int i = lvl; i > 0; i--) begin
         d = came_from[cy * GW + cx];
         path_steps[i - 1] = d;
         if (!step_cell(cx, cy, d + 3'd4, nx, ny)) break;
         cx = nx;
         cy = ny;
      end
      path_count = lvl;
      report = lvl;
      return ST_OK;
   endfunction

   function automatic grid_rsp_type predict_rsp(input grid_req_type r);
      grid_rsp_type o;
      int len;
      o = '0;
      len = path_count;
      if (r.action == ACT_SEARCH) begin
         o.status = find_path(r.x_pos, r.y_pos, r.target_x, r.target_y, len);
      end else if (r.action == ACT_READ) begin
         if (step_ptr < path_count) begin
            o.direction = path_steps[step_ptr];
            o.last_step = (step_ptr + 1 == path_count);
            step_ptr++;
         end else begin
            o.status = ST_PAST_END;
         end
      end else if (r.action == ACT_WRITE) begin
         blocked_cells[r.y_pos * GW + r.x_pos] = r.blocked_bit;
      end
      o.path_length = len[7:0];
      return o;
   endfunction

   // Receiver: random ready gaps, with a long hold-off when requested.
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock iff rsp_chan.valid);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      grid_rsp_type got;
      grid_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.status, rsp_chan.path_length, rsp_chan.direction,
                 rsp_chan.last_step};
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Valid stays up after a transaction until the next call replaces the item or idles it.
   task automatic send_req(input grid_req_type r, input bit no_gap = 0);
      int gap;
      grid_rsp_type want;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= r.action;
      req_chan.x_pos <= r.x_pos;
      req_chan.y_pos <= r.y_pos;
      req_chan.target_x <= r.target_x;
      req_chan.target_y <= r.target_y;
      req_chan.blocked_bit <= r.blocked_bit;
      @(posedge clock iff req_chan.ready);
      want = predict_rsp(r);
      expected_rsps = {expected_rsps, want};
   endtask

   task automatic drain_rsps();
      req_chan.valid <= 1'b0;
      wait (expected_rsps.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] val);
      drain_rsps();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_MODE) fight_mode = val[0];
      else level_cap = val;
   endtask

   function automatic grid_req_type mk(input logic [1:0] a, input int x, input int y,
                                       input int tx, input int ty, input bit b);
      grid_req_type r;
      r = '{a, x[4:0], y[5:0], tx[4:0], ty[5:0], b};
      return r;
   endfunction

   task automatic read_path(input int n);
      for (int i = 0; i < n; i++) send_req(mk(ACT_READ, 0, 0, 0, 0, 0));
   endtask

   task automatic test_directed();
      send_req(mk(ACT_READ, 0, 0, 0, 0, 0));
      send_req(mk(ACT_SEARCH, 5, 5, 5, 5, 0));
      send_req(mk(ACT_SEARCH, 0, 0, 31, 63, 0));
      read_path(3);
      send_req(mk(ACT_WRITE, 31, 63, 0, 0, 1));
      send_req(mk(ACT_SEARCH, 0, 0, 31, 63, 0));
      send_req(mk(ACT_WRITE, 31, 63, 31, 63, 0));
      send_req(mk(ACT_SPARE, 1, 1, 0, 0, 1));
      send_req(mk(ACT_WRITE, 10, 10, 0, 0, 1));
      send_req(mk(ACT_SEARCH, 10, 10, 12, 20, 0));
      read_path(8);
      send_req(mk(ACT_WRITE, 10, 10, 0, 0, 0));
      write_csr(REG_MODE, 8'd1);
      write_csr(REG_LIMIT, 8'd0);
      send_req(mk(ACT_SEARCH, 3, 3, 3, 3, 0));
      write_csr(REG_LIMIT, 8'd255);
      send_req(mk(ACT_SEARCH, 0, 1, 1, 1, 0));
      send_req(mk(ACT_SEARCH, 0, 0, 20, 40, 0));
      read_path(3);
   endtask

   // Long paths: a walled corridor forces a route longer than the path store.
   task automatic test_too_long();
      write_csr(REG_MODE, 8'd0);
      // Snake walls in the odd columns below 10, each open at one end only.
      for (int x = 1; x < 10; x += 2)
         for (int y = 0; y < GH; y++)
            send_req(mk(ACT_WRITE, x, y, 0, 0,
                        !((((x - 1) / 2) % 2 == 0) ? (y >= 62) : (y <= 1))), 1);
      send_req(mk(ACT_SEARCH, 0, 0, 10, 0, 0));
      read_path(2);
      send_req(mk(ACT_SEARCH, 0, 0, 2, 0, 0));
      read_path(4);
      for (int x = 1; x < 10; x += 2)
         for (int y = 0; y < GH; y++)
            send_req(mk(ACT_WRITE, x, y, 0, 0, 0), 1);
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      for (int i = 0; i < 40; i++)
         send_req(mk($urandom_range(0, 1) ? ACT_READ : ACT_WRITE, $urandom_range(0, 31),
                     $urandom_range(0, 63), 0, 0, 0), 1);
      drain_rsps();
   endtask

   task automatic test_random(input int n);
      int x;
      int y;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         x = $urandom_range(0, 31);
         y = $urandom_range(0, 63);
         if (r < 45) begin
            send_req(mk(ACT_WRITE, x, y, 0, 0, $urandom_range(0, 9) < 3));
         end else if (r < 60) begin
            if ($urandom_range(0, 1))
               send_req(mk(ACT_SEARCH, x, y, $urandom_range(0, 31), $urandom_range(0, 63),
                           $urandom_range(0, 1)));
            else
               send_req(mk(ACT_SEARCH, x, y, (x + $urandom_range(0, 6)) % GW,
                           (y + $urandom_range(0, 12)) % GH, 0));
         end else if (r < 97) begin
            send_req(mk(ACT_READ, x, y, $urandom_range(0, 31), $urandom_range(0, 63),
                        $urandom_range(0, 1)));
         end else begin
            send_req(mk(ACT_SPARE, x, y, $urandom_range(0, 31), $urandom_range(0, 63), 1));
         end
      end
   endtask

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.action <= ACT_WRITE;
      req_chan.x_pos <= '0;
      req_chan.y_pos <= '0;
      req_chan.target_x <= '0;
      req_chan.target_y <= '0;
      req_chan.blocked_bit <= 1'b0;
      fight_mode = 0;
      level_cap = 255;
      step_ptr = 0;
      path_count = 0;
      foreach (blocked_cells[i]) blocked_cells[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_too_long();
      test_backpressure();
      write_csr(REG_MODE, 8'd0);
      test_random(200);
      write_csr(REG_MODE, 8'd1);
      write_csr(REG_LIMIT, 8'd12);
      test_random(200);
      write_csr(REG_LIMIT, 8'd1);
      test_random(100);
      write_csr(REG_LIMIT, 8'd255);
      test_random(100);
      write_csr(REG_MODE, 8'd0);
      test_random(130);
      drain_rsps();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
